[design/srmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmd_pkg
// Shared types and constants of the sensor reply minifloat decoder: queue
// entry layout, status and quantity codes, and fixed-point constants.
// ----------------------------------------------------------------------------
package srmd_pkg;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;
  localparam int VALUE_W     = 38;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_ID_BAD   = 2'd1;
  localparam status_t STATUS_SUM_BAD  = 2'd2;
  localparam status_t STATUS_ZERO_PAY = 2'd3;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_RESISTANCE  = 2'd0;
  localparam kind_t KIND_VOLTAGE     = 2'd1;
  localparam kind_t KIND_TEMPERATURE = 2'd2;

  localparam logic       CMD_REQUEST   = 1'b0;
  localparam logic [7:0] BROADCAST_ID  = 8'hff;
  localparam logic [9:0] RES_SCALE     = 10'd1000;
  localparam logic [28:0] TEMP_OFFSET_Q = 29'd8388608;   // 32 in Q.18
  localparam logic [28:0] RECIP9        = 29'd477218588; // floor(2^32 / 9)

  typedef struct packed {
    logic    is_req;
    logic [7:0] byte_a;  // device id, or payload high byte
    logic [7:0] byte_b;  // command byte, or payload low byte
    kind_t   kind;
    status_t status;
    logic    link;
  } entry_t;

endpackage

[design/sensor_reply_minifloat_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_reply_minifloat_decoder_core
// Polls a sensor over a byte link: expands requests into three transmit
// bytes, checks four-byte replies and decodes their minifloat payload.
// ----------------------------------------------------------------------------
//  Channel  Dir  tdata (low bit first)                            tuser / tlast
//  s_*      in   device_id, request_code, quantity_kind, rx_byte   command / -
//  m_*      out  tx_byte, value, status, link_error               result_kind / last_of_run
//
//  A decoded reply leaves as one output word; a request leaves as three.
//  After its last byte is accepted, a reply passes the queue, the pipeline and the output register.
//  The request expansion in the output register holds the pipeline and so sets the rate.
//  Reset clears the link state, the queue and the pipeline valid bits.
//  The front and the back stall independently through the entry queue.
// ----------------------------------------------------------------------------
module sensor_reply_minifloat_decoder_core #(
  parameter int QUEUE_DEPTH = srmd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // device_id[7:0], request_code[15:8], quantity_kind[17:16], rx_byte[25:18]
  input  logic [srmd_pkg::IN_TDATA_W-1:0]  s_tdata,
  // command
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // tx_byte[7:0], value[45:8], status[47:46], link_error[48]
  output logic [srmd_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tlast,
  // result_kind
  output logic                             m_tuser
);
  import srmd_pkg::*;

  logic   accept;
  logic   q_push, q_pop, q_valid, q_full;
  entry_t q_in, q_head;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  srmd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .command   (s_tuser),
    .data      (s_tdata),
    .push      (q_push),
    .push_data (q_in)
  );

  srmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .not_empty (q_valid),
    .full      (q_full),
    .head      (q_head)
  );

  srmd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("Entry pushed into a full queue.");

  a_last_on_tx: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> !m_tuser)
    else $error("Last marker on a decoded reply word.");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser && m_tdata[47:46] != STATUS_OK) |-> (m_tdata[45:8] == '0))
    else $error("Nonzero value on a failed reply.");

  a_tx_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[48:8] == '0))
    else $error("Reply fields set on a transmit word.");

endmodule

[design/srmd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmd_front
// Accepts request and reply words, tracks the link state, checks completed
// replies and pushes one classified entry per request or finished reply.
// ----------------------------------------------------------------------------
module srmd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          command,
  input  logic [srmd_pkg::IN_TDATA_W-1:0] data,
  output logic                          push,
  output srmd_pkg::entry_t              push_data
);
  import srmd_pkg::*;

  logic [7:0] device_id;
  logic [7:0] request_code;
  kind_t      quantity_kind;
  logic [7:0] rx_byte;

  logic [7:0] sent_id, sent_id_next;
  kind_t      kind_held, kind_held_next;
  logic [1:0] byte_position, byte_position_next;
  logic       link_error_flag, link_error_flag_next;
  logic [7:0] reply_bytes [3];
  status_t    status;

  assign device_id     = data[7:0];
  assign request_code  = data[15:8];
  assign quantity_kind = data[17:16];
  assign rx_byte       = data[25:18];

  always_comb begin
    push                 = 1'b0;
    push_data            = '0;
    status               = STATUS_OK;
    sent_id_next         = sent_id;
    kind_held_next       = kind_held;
    byte_position_next   = byte_position;
    link_error_flag_next = link_error_flag;
    if (accept) begin
      if (command == CMD_REQUEST) begin
        push               = 1'b1;
        push_data.is_req   = 1'b1;
        push_data.byte_a   = device_id;
        push_data.byte_b   = request_code;
        sent_id_next       = device_id;
        kind_held_next     = quantity_kind;
        byte_position_next = 2'd0;
      end else if (byte_position != 2'd3) begin
        byte_position_next = byte_position + 2'd1;
      end else begin
        byte_position_next = 2'd0;
        if (reply_bytes[0] != sent_id) begin
          status = STATUS_ID_BAD;
          if (!(sent_id == BROADCAST_ID && kind_held != KIND_RESISTANCE)) begin
            link_error_flag_next = 1'b1;
          end
        end else if ((reply_bytes[0] ^ reply_bytes[1] ^ reply_bytes[2]) != rx_byte) begin
          status = STATUS_SUM_BAD;
        end else if (reply_bytes[1] == 8'd0 && reply_bytes[2] == 8'd0) begin
          status               = STATUS_ZERO_PAY;
          link_error_flag_next = 1'b1;
        end else begin
          status               = STATUS_OK;
          link_error_flag_next = 1'b0;
        end
        push             = 1'b1;
        push_data.is_req = 1'b0;
        push_data.byte_a = reply_bytes[1];
        push_data.byte_b = reply_bytes[2];
        push_data.kind   = kind_held;
        push_data.status = status;
        push_data.link   = link_error_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_id         <= 8'd0;
      kind_held       <= KIND_RESISTANCE;
      byte_position   <= 2'd0;
      link_error_flag <= 1'b0;
    end else begin
      sent_id         <= sent_id_next;
      kind_held       <= kind_held_next;
      byte_position   <= byte_position_next;
      link_error_flag <= link_error_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && command != CMD_REQUEST && byte_position != 2'd3) begin
      reply_bytes[byte_position] <= rx_byte;
    end
  end

endmodule

[design/srmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmd_queue
// Short register queue of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module srmd_queue #(
  parameter int DEPTH = srmd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  srmd_pkg::entry_t push_data,
  input  logic             pop,
  output logic             not_empty,
  output logic             full,
  output srmd_pkg::entry_t head
);
  import srmd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(DEPTH));
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[design/srmd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmd_back
// Pipeline that decodes the minifloat payload, scales it by quantity kind,
// and drives the output register, which expands a request into three words.
// ----------------------------------------------------------------------------
module srmd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  srmd_pkg::entry_t               q_head,
  output logic                           q_pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [srmd_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                           m_tlast,
  output logic                           m_tuser
);
  import srmd_pkg::*;

  logic en;

  logic v1, v2, v3, v4, v5;
  entry_t e1, e2, e3, e4, e5;

  logic [3:0]  exp1;
  logic [11:0] man1;
  logic [26:0] mag1;
  logic [36:0] res1;

  logic [26:0] mag2;
  logic [36:0] res2;
  logic signed [VALUE_W-1:0] val2;
  logic signed [28:0] qoff2;

  logic signed [VALUE_W-1:0] val3;
  logic signed [28:0] qoff3;
  logic signed [30:0] t3;
  logic [30:0] abs3;
  logic [29:0] n3;

  logic signed [VALUE_W-1:0] val4;
  logic [29:0] n4;
  logic        neg4;
  logic [58:0] prod4;

  logic signed [VALUE_W-1:0] val5;
  logic [29:0] n5;
  logic        neg5;
  logic [26:0] q05;
  logic [29:0] rem5;
  logic [26:0] quo5;
  logic signed [VALUE_W-1:0] final5;

  logic       out_valid;
  entry_t     out_ent;
  logic signed [VALUE_W-1:0] out_value;
  logic [1:0] cnt;
  logic [7:0] tx_byte;
  logic       last_word;

  assign last_word = !out_ent.is_req || cnt == 2'd2;
  assign en        = !out_valid || (m_tready && last_word);
  assign q_pop     = en && q_valid;

  assign exp1 = e1.byte_a[6:3];
  assign man1 = {1'b1, e1.byte_a[2:0], e1.byte_b};
  assign mag1 = 27'(man1) << exp1;
  assign res1 = 37'(mag1) * 37'(RES_SCALE);

  always_comb begin
    if (e2.is_req || e2.status != STATUS_OK) begin
      val2 = '0;
    end else if (e2.kind == KIND_RESISTANCE) begin
      val2 = e2.byte_a[7] ? -$signed({1'b0, res2}) : $signed({1'b0, res2});
    end else begin
      val2 = e2.byte_a[7] ? -$signed(38'(mag2)) : $signed(38'(mag2));
    end
    qoff2 = (e2.byte_a[7] ? -$signed(29'(mag2)) : $signed(29'(mag2)))
            - $signed(TEMP_OFFSET_Q);
  end

  assign t3   = (31'(qoff3) <<< 2) + 31'(qoff3);
  assign abs3 = t3[30] ? 31'(-t3) : 31'(t3);
  assign n3   = abs3[29:0] + 30'd4;

  assign prod4 = 59'(n4) * 59'(RECIP9);

  always_comb begin
    rem5 = n5 - ((30'(q05) << 3) + 30'(q05));
    quo5 = (rem5 >= 30'd9) ? q05 + 27'd1 : q05;
    if (!e5.is_req && e5.status == STATUS_OK && e5.kind == KIND_TEMPERATURE) begin
      final5 = neg5 ? -$signed(38'(quo5)) : $signed(38'(quo5));
    end else begin
      final5 = val5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
      cnt <= 2'd0;
    end else if (en) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
      cnt <= 2'd0;
    end else if (out_valid && m_tready) begin
      cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1 <= q_head;
      e2 <= e1;
      mag2 <= mag1;
      res2 <= res1;
      e3 <= e2;
      val3 <= val2;
      qoff3 <= qoff2;
      e4 <= e3;
      val4 <= val3;
      n4 <= n3;
      neg4 <= t3[30];
      e5 <= e4;
      val5 <= val4;
      n5 <= n4;
      neg5 <= neg4;
      q05 <= prod4[58:32];
      out_ent <= e5;
      out_value <= final5;
    end
  end

  always_comb begin
    case (cnt)
      2'd0:    tx_byte = out_ent.byte_a;
      2'd1:    tx_byte = out_ent.byte_b;
      2'd2:    tx_byte = out_ent.byte_a ^ out_ent.byte_b;
      default: tx_byte = 8'd0;
    endcase
    if (!out_ent.is_req) begin
      tx_byte = 8'd0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = !out_ent.is_req;
  assign m_tlast  = out_ent.is_req && cnt == 2'd2;
  assign m_tdata  = {7'd0, out_ent.link, out_ent.status, out_value, tx_byte};

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sensor reply minifloat decoder core. Requests
// and reply bytes are driven on the input stream while a predictor tracks the
// link state and queues the transmit bytes and decoded replies that the core
// must emit. Each output word is compared field by field against that queue.
// Both stream sides are throttled at random in phases.
// ----------------------------------------------------------------------------
module testbench;
  import srmd_pkg::*;

  localparam logic  CMD_REPLY_BYTE = 1'b1;
  localparam logic  RESULT_TX      = 1'b0;
  localparam logic  RESULT_REPLY   = 1'b1;
  localparam kind_t KIND_SPARE     = 2'd3;
  localparam int    RANDOM_WORDS   = 200;
  localparam int    TAIL_CYCLES    = 20;
  localparam int    CYCLE_LIMIT    = 200000;

  typedef struct {
    logic       cmd;
    logic [7:0] id;
    logic [7:0] code;
    kind_t      kind;
    logic [7:0] rx;
  } link_word_t;

  typedef struct {
    logic        kind;
    logic [7:0]  tx;
    logic        last;
    logic [37:0] value;
    status_t     status;
    logic        link;
  } out_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;

  link_word_t pending_words[$];
  out_word_t  due_outputs[$];
  link_word_t word_on_bus;
  int         total_words = 1;
  int         accepted_words = 0;
  int         mismatch_count = 0;
  int         cycle_count = 0;

  logic [7:0] held_id = 8'h00;
  kind_t      held_kind = KIND_RESISTANCE;
  int         rx_count = 0;
  logic [7:0] rx_buf [3];
  logic       link_flag = 1'b0;

  sensor_reply_minifloat_decoder_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int idle_phase();
    if (accepted_words < total_words / 3) return 0;
    if (accepted_words < 2 * total_words / 3) return 1;
    return 2;
  endfunction

  function automatic longint minifloat_q18(logic [7:0] hi, logic [7:0] lo);
    longint mant;
    longint mag;
    mant = 2048 + (longint'(hi[2:0]) << 8) + longint'(lo);
    mag = mant << hi[6:3];
    return hi[7] ? -mag : mag;
  endfunction

  function automatic longint fahrenheit_to_celsius_q18(longint q);
    longint t;
    t = (q - (longint'(32) << 18)) * 5;
    if (t < 0) return -((-t + 4) / 9);
    return (t + 4) / 9;
  endfunction

  task automatic push_output(logic kind, logic [7:0] tx, logic last, longint val,
                             status_t st, logic link);
    out_word_t o;
    o.kind = kind;
    o.tx = tx;
    o.last = last;
    o.value = val[37:0];
    o.status = st;
    o.link = link;
    due_outputs.push_back(o);
  endtask

  task automatic predict_link_outputs(link_word_t w);
    status_t st;
    longint  val;
    val = 0;
    if (w.cmd == CMD_REQUEST) begin
      held_id = w.id;
      held_kind = w.kind;
      rx_count = 0;
      push_output(RESULT_TX, w.id, 1'b0, 0, STATUS_OK, 1'b0);
      push_output(RESULT_TX, w.code, 1'b0, 0, STATUS_OK, 1'b0);
      push_output(RESULT_TX, w.id ^ w.code, 1'b1, 0, STATUS_OK, 1'b0);
    end else if (rx_count < 3) begin
      rx_buf[rx_count] = w.rx;
      rx_count++;
    end else begin
      rx_count = 0;
      if (rx_buf[0] != held_id) begin
        st = STATUS_ID_BAD;
        if (!(held_id == BROADCAST_ID && held_kind != KIND_RESISTANCE)) link_flag = 1'b1;
      end else if ((rx_buf[0] ^ rx_buf[1] ^ rx_buf[2]) != w.rx) begin
        st = STATUS_SUM_BAD;
      end else if (rx_buf[1] == 8'h00 && rx_buf[2] == 8'h00) begin
        st = STATUS_ZERO_PAY;
        link_flag = 1'b1;
      end else begin
        st = STATUS_OK;
        val = minifloat_q18(rx_buf[1], rx_buf[2]);
        if (held_kind == KIND_RESISTANCE) val = val * 1000;
        else if (held_kind == KIND_TEMPERATURE) val = fahrenheit_to_celsius_q18(val);
        link_flag = 1'b0;
      end
      push_output(RESULT_REPLY, 8'h00, 1'b0, val, st, link_flag);
    end
  endtask

  task automatic add_request(logic [7:0] id, logic [7:0] code, kind_t kind);
    link_word_t w;
    w.cmd = CMD_REQUEST;
    w.id = id;
    w.code = code;
    w.kind = kind;
    w.rx = 8'($urandom);
    pending_words.push_back(w);
  endtask

  task automatic add_rx_byte(logic [7:0] b);
    link_word_t w;
    w.cmd = CMD_REPLY_BYTE;
    w.id = 8'($urandom);
    w.code = 8'($urandom);
    w.kind = kind_t'($urandom);
    w.rx = b;
    pending_words.push_back(w);
  endtask

  task automatic add_reply(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
    add_rx_byte(b0);
    add_rx_byte(b1);
    add_rx_byte(b2);
    add_rx_byte(b3);
  endtask

  task automatic add_good_reply(logic [7:0] id, logic [7:0] hi, logic [7:0] lo);
    add_reply(id, hi, lo, id ^ hi ^ lo);
  endtask

  task automatic add_random_exchange();
    logic [7:0] id;
    logic [7:0] hi;
    logic [7:0] lo;
    kind_t      kind;
    int         pick;
    int         n;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      add_rx_byte(8'($urandom));
      return;
    end
    id = 8'($urandom);
    if (pick < 15) id = BROADCAST_ID;
    else if (pick < 20) id = 8'h00;
    kind = ($urandom_range(0, 9) == 0) ? KIND_SPARE : kind_t'($urandom_range(0, 2));
    add_request(id, 8'($urandom), kind);
    hi = 8'($urandom);
    lo = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      add_good_reply(id, hi, lo);
    end else if (pick < 72) begin
      add_reply(id ^ 8'($urandom_range(1, 255)), hi, lo, 8'($urandom));
    end else if (pick < 84) begin
      add_reply(id, hi, lo, id ^ hi ^ lo ^ 8'($urandom_range(1, 255)));
    end else if (pick < 92) begin
      add_good_reply(id, 8'h00, 8'h00);
    end else begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) add_rx_byte(8'($urandom));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_link_outputs(word_on_bus);
        accepted_words++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() > 0 &&
            $urandom_range(0, 99) >= (idle_phase() == 0 ? 22 : idle_phase() == 1 ? 49 : 0)) begin
          word_on_bus = pending_words.pop_front();
          s_tdata <= {6'b0, word_on_bus.rx, word_on_bus.kind, word_on_bus.code, word_on_bus.id};
          s_tuser <= word_on_bus.cmd;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(0, 99) >=
                  (idle_phase() == 0 ? 49 : idle_phase() == 1 ? 22 : 0);
      if (m_tvalid && m_tready) begin
        if (due_outputs.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected output word: kind %0b tdata %h last %0b",
                     m_tuser, m_tdata, m_tlast);
        end else begin
          want = due_outputs.pop_front();
          if (m_tuser !== want.kind || m_tdata[7:0] !== want.tx || m_tlast !== want.last ||
              m_tdata[45:8] !== want.value || m_tdata[47:46] !== want.status ||
              m_tdata[48] !== want.link) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $write("Mismatch: expected kind %0b tx %h last %0b value %h status %0d link %0b, ",
                     want.kind, want.tx, want.last, want.value, want.status, want.link);
              $display("got kind %0b tx %h last %0b value %h status %0d link %0b",
                       m_tuser, m_tdata[7:0], m_tlast, m_tdata[45:8], m_tdata[47:46],
                       m_tdata[48]);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int directed;
    // A reply before any request is checked against the reset id of zero.
    add_good_reply(8'h00, 8'h38, 8'h00);
    // Broadcast id with a mismatching echo leaves the link flag alone.
    add_request(BROADCAST_ID, 8'h00, KIND_TEMPERATURE);
    add_good_reply(8'h12, 8'h40, 8'h10);
    add_request(8'h00, 8'hff, KIND_RESISTANCE);
    add_good_reply(8'h00, 8'h00, 8'h00);
    // A new request drops a partly received reply.
    add_request(8'ha5, 8'h5a, KIND_VOLTAGE);
    add_rx_byte(8'ha5);
    add_rx_byte(8'h7f);
    add_request(8'ha5, 8'h5a, KIND_SPARE);
    add_reply(8'ha5, 8'h7f, 8'hff, 8'h00);
    add_good_reply(8'ha5, 8'hff, 8'hff);
    directed = pending_words.size();
    while (pending_words.size() < directed + RANDOM_WORDS) add_random_exchange();
    total_words = pending_words.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (pending_words.size() > 0 || s_tvalid) @(posedge clk);
    while (due_outputs.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && due_outputs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
